FILE: rtl/btw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// btw_pkg
// Shared types and constants for the BER TLV header walker.
// ----------------------------------------------------------------------------
package btw_pkg;

    localparam int POSITION_BITS_DEF = 16;
    localparam logic [7:0] MAX_ELEMENTS_RESET = 8'd9;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_UNKNOWN = 2'd1;
    localparam logic [1:0] ST_TRUNC   = 2'd2;

    typedef struct packed {
        logic [7:0]  element_tag;
        logic [31:0] content_length;
        logic [15:0] content_offset;
        logic [7:0]  element_index;
        logic [1:0]  status;
    } btw_result_t;

endpackage : btw_pkg
`default_nettype wire

FILE: rtl/btw_walker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// btw_walker
// Input beat register, walk state and the per-byte header decode step.
// ----------------------------------------------------------------------------
module btw_walker
    import btw_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [7:0]  cfg_wr_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        s_first_byte,
    input  wire logic        s_last_byte,
    input  wire logic        out_free,
    output logic             res_load,
    output btw_result_t      res
);

    localparam logic [1:0] PH_TAG  = 2'd0;
    localparam logic [1:0] PH_LEN  = 2'd1;
    localparam logic [1:0] PH_LONG = 2'd2;
    localparam logic [1:0] PH_SKIP = 2'd3;

    localparam logic [7:0] TAG_BOOLEAN  = 8'd1;
    localparam logic [7:0] TAG_NULL     = 8'd5;
    localparam logic [7:0] TAG_OID      = 8'd6;
    localparam logic [7:0] TAG_SEQUENCE = 8'd48;

    logic                     in_valid_reg;
    logic [7:0]               data_reg;
    logic                     first_reg;
    logic                     last_reg;
    logic [7:0]               max_elements_reg;

    logic [1:0]               phase_reg, phase_next;
    logic [7:0]               tag_reg, tag_next;
    logic [31:0]              acc_reg, acc_next;
    logic [6:0]               left_reg, left_next;
    logic [31:0]              content_reg, content_next;
    logic [7:0]               count_reg, count_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic                     stopped_reg, stopped_next;

    logic [1:0]               phase_eff;
    logic [7:0]               count_eff;
    logic [POSITION_BITS-1:0] pos_eff;
    logic                     stopped_eff;
    logic [POSITION_BITS-1:0] pos_inc;
    logic [POSITION_BITS+15:0] pos_wide;
    logic [31:0]              acc_shift;
    logic [31:0]              content_dec;
    logic [31:0]              done_len;
    logic                     done;
    logic                     hit;
    logic                     step_go;

    assign step_go = in_valid_reg && out_free;
    assign s_ready = !in_valid_reg || out_free;

    assign phase_eff   = first_reg ? PH_TAG : phase_reg;
    assign count_eff   = first_reg ? 8'd0 : count_reg;
    assign pos_eff     = first_reg ? '0 : pos_reg;
    assign stopped_eff = first_reg ? 1'b0 : stopped_reg;
    assign pos_inc     = pos_eff + POSITION_BITS'(1);
    assign pos_wide    = {16'd0, pos_inc};
    assign acc_shift   = {acc_reg[23:0], data_reg};
    assign content_dec = (content_reg != 32'd0) ? content_reg - 32'd1 : 32'd0;

    always_comb begin
        phase_next   = phase_eff;
        tag_next     = tag_reg;
        acc_next     = acc_reg;
        left_next    = left_reg;
        content_next = content_reg;
        count_next   = count_eff;
        pos_next     = pos_eff;
        stopped_next = stopped_eff;
        done         = 1'b0;
        done_len     = 32'd0;
        hit          = 1'b0;
        res.element_tag    = tag_reg;
        res.content_length = 32'd0;
        res.content_offset = 16'd0;
        res.element_index  = count_eff;
        res.status         = ST_TRUNC;

        if (!stopped_eff) begin
            pos_next = pos_inc;
            case (phase_eff)
                PH_TAG: begin
                    if (count_eff >= max_elements_reg) begin
                        stopped_next = 1'b1;
                    end else if (data_reg inside {TAG_BOOLEAN, TAG_NULL, TAG_OID,
                                                  TAG_SEQUENCE}) begin
                        tag_next        = data_reg;
                        phase_next      = PH_LEN;
                        res.element_tag = data_reg;
                        hit             = last_reg;
                    end else begin
                        res.element_tag = data_reg;
                        res.status      = ST_UNKNOWN;
                        stopped_next    = 1'b1;
                        hit             = 1'b1;
                    end
                end
                PH_LEN: begin
                    if (!data_reg[7]) begin
                        done     = 1'b1;
                        done_len = {24'd0, data_reg};
                    end else begin
                        left_next = data_reg[6:0];
                        acc_next  = 32'd0;
                        if (data_reg[6:0] == 7'd0) begin
                            done = 1'b1;
                        end else begin
                            phase_next = PH_LONG;
                            hit        = last_reg;
                        end
                    end
                end
                PH_LONG: begin
                    acc_next  = acc_shift;
                    left_next = left_reg - 7'd1;
                    if (left_next == 7'd0) begin
                        done     = 1'b1;
                        done_len = acc_shift;
                    end else begin
                        hit = last_reg;
                    end
                end
                default: begin
                    content_next = content_dec;
                    if (content_dec == 32'd0) begin
                        phase_next = PH_TAG;
                    end
                end
            endcase

            if (done) begin
                hit                = 1'b1;
                res.status         = ST_OK;
                res.content_length = done_len;
                res.content_offset = pos_wide[15:0];
                count_next         = count_eff + 8'd1;
                content_next       = done_len;
                phase_next         = (done_len == 32'd0) ? PH_TAG : PH_SKIP;
            end
            if (last_reg) begin
                stopped_next = 1'b1;
            end
        end
    end

    assign res_load = step_go && hit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg     <= 1'b0;
            max_elements_reg <= MAX_ELEMENTS_RESET;
            phase_reg        <= PH_TAG;
            tag_reg          <= 8'd0;
            acc_reg          <= 32'd0;
            left_reg         <= 7'd0;
            content_reg      <= 32'd0;
            count_reg        <= 8'd0;
            pos_reg          <= '0;
            stopped_reg      <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                max_elements_reg <= cfg_wr_data;
            end
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (step_go) begin
                phase_reg   <= phase_next;
                tag_reg     <= tag_next;
                acc_reg     <= acc_next;
                left_reg    <= left_next;
                content_reg <= content_next;
                count_reg   <= count_next;
                pos_reg     <= pos_next;
                stopped_reg <= stopped_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            data_reg  <= s_data_byte;
            first_reg <= s_first_byte;
            last_reg  <= s_last_byte;
        end
    end

`ifndef SYNTHESIS
    a_hold_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !out_free |=> in_valid_reg && $stable(data_reg))
        else $error("buffered beat lost while result stage full");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        res_load && res.status != ST_OK |->
            res.content_length == 32'd0 && res.content_offset == 16'd0)
        else $error("error result carries length or offset");

    a_count_inc: assert property (@(posedge aclk) disable iff (!aresetn)
        res_load && res.status == ST_OK |=> count_reg == $past(count_eff) + 8'd1)
        else $error("element count not advanced on header");

    a_stop_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        step_go && stopped_eff |-> !res_load && pos_next == pos_eff)
        else $error("stopped walk produced activity");
`endif

endmodule : btw_walker
`default_nettype wire

FILE: rtl/btw_out_reg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// btw_out_reg
// Result register: holds one header beat until the receiver takes it.
// ----------------------------------------------------------------------------
module btw_out_reg
    import btw_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         load,
    input  wire btw_result_t  load_data,
    output logic              out_free,
    output logic              m_valid,
    input  wire logic         m_ready,
    output btw_result_t       m_data
);

    logic        valid_reg;
    btw_result_t data_reg;

    assign out_free = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign m_data   = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= load_data;
        end
    end

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && !m_ready |-> !load)
        else $error("pending result overwritten");

    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> valid_reg && data_reg == $past(load_data))
        else $error("loaded result not presented");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> data_reg.status == ST_OK || data_reg.status == ST_UNKNOWN ||
                      data_reg.status == ST_TRUNC)
        else $error("reserved status code on output");
`endif

endmodule : btw_out_reg
`default_nettype wire

FILE: rtl/ber_tlv_header_walker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ber_tlv_header_walker
// Walks the top-level TLV headers of a BER message, one byte per beat.
//
// Input channel s_*: one message byte per beat; s_first_byte restarts the
// walk at position zero, s_last_byte closes the message. Result channel m_*:
// one beat for each completed header (status ok), for an unknown tag (walk
// stops) or for a message ending inside a header. Content bytes, trailing
// bytes and bytes past the element limit give no beat.
// cfg_wr_en/cfg_wr_data write max_elements (reset value 9); write only while
// no beat is in flight.
// A taken byte is held in the input register; the result register loads its
// beat from there, and m_* is driven straight from the result register.
// Throughput: one byte per cycle while the result register is free, through
// the combinational decode step between the input and result registers.
// Reset (aresetn low, synchronous) empties both registers and restarts the
// walk. When the receiver stalls, the result register holds its beat; one
// more byte is buffered and s_ready then drops until m_ready returns.
// ----------------------------------------------------------------------------
module ber_tlv_header_walker
    import btw_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [7:0]  cfg_wr_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        s_first_byte,
    input  wire logic        s_last_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_element_tag,
    output logic [31:0]      m_content_length,
    output logic [15:0]      m_content_offset,
    output logic [7:0]       m_element_index,
    output logic [1:0]       m_status
);

    logic        out_free;
    logic        res_load;
    btw_result_t res;
    btw_result_t m_data;

    btw_walker #(
        .POSITION_BITS (POSITION_BITS)
    ) u_walker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_byte  (s_data_byte),
        .s_first_byte (s_first_byte),
        .s_last_byte  (s_last_byte),
        .out_free     (out_free),
        .res_load     (res_load),
        .res          (res)
    );

    btw_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (res_load),
        .load_data (res),
        .out_free  (out_free),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    assign m_element_tag    = m_data.element_tag;
    assign m_content_length = m_data.content_length;
    assign m_content_offset = m_data.content_offset;
    assign m_element_index  = m_data.element_index;
    assign m_status         = m_data.status;

endmodule : ber_tlv_header_walker
`default_nettype wire

FILE: sim/ber_tlv_header_walker_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ber_tlv_header_walker_tb
// Self-checking bench for the BER TLV header walker.
//
// A short table of hand-built messages runs first: tag and length extremes,
// long form, unknown tag, truncated headers and a message that ends inside
// content. After that come random phases, one max_elements setting each.
// Most messages are well-formed TLV runs with random content, and the rest
// are noise or broken framing.
// A local walker predicts each result beat unless a table row gives its own;
// each beat on m_* is checked field by field against the oldest prediction.
// Both sides idle in random bursts; once the receiver holds off a long stretch.
// ----------------------------------------------------------------------------
module ber_tlv_header_walker_tb;
    import btw_pkg::*;

    localparam int HOLD_CYCLES   = 200;
    localparam int SETTLE_CYCLES = 8;

    typedef enum logic [7:0] {
        TAG_BOOLEAN  = 8'h01,
        TAG_NULL     = 8'h05,
        TAG_OID      = 8'h06,
        TAG_SEQUENCE = 8'h30
    } ber_tag_t;

    localparam logic [7:0] LEN_LONG_FORM = 8'h80;

    typedef enum logic [1:0] {
        WALK_TAG,
        WALK_LEN,
        WALK_LONG,
        WALK_SKIP
    } walk_phase_t;

    typedef struct packed {
        logic [7:0] data;
        logic       first;
        logic       last;
    } msg_byte_t;

    typedef struct packed {
        msg_byte_t   beat;
        logic        typed;
        btw_result_t result;
    } table_row_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [7:0]  cfg_wr_data;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_data_byte;
    logic        s_first_byte;
    logic        s_last_byte;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_element_tag;
    logic [31:0] m_content_length;
    logic [15:0] m_content_offset;
    logic [7:0]  m_element_index;
    logic [1:0]  m_status;

    ber_tlv_header_walker dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .s_first_byte     (s_first_byte),
        .s_last_byte      (s_last_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_element_tag    (m_element_tag),
        .m_content_length (m_content_length),
        .m_content_offset (m_content_offset),
        .m_element_index  (m_element_index),
        .m_status         (m_status)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // walker state
    walk_phase_t w_phase;
    logic [7:0]  w_tag;
    logic [31:0] w_acc;
    logic [6:0]  w_len_left;
    logic [31:0] w_skip;
    logic [7:0]  w_count;
    logic [15:0] w_pos;
    logic        w_stopped;
    logic [7:0]  w_limit;

    btw_result_t header_q [$];
    msg_byte_t   msg_q [$];
    table_row_t  dir_rows [$];

    int mismatches;
    bit idle_on;
    bit hold_req;

    function automatic bit is_known_tag(input logic [7:0] b);
        return b == TAG_BOOLEAN || b == TAG_NULL || b == TAG_OID || b == TAG_SEQUENCE;
    endfunction

    function automatic void restart_walk();
        w_phase    = WALK_TAG;
        w_tag      = '0;
        w_acc      = '0;
        w_len_left = '0;
        w_skip     = '0;
        w_count    = '0;
        w_pos      = '0;
        w_stopped  = 1'b0;
    endfunction

    function automatic btw_result_t truncated_header();
        return {w_tag, 32'd0, 16'd0, w_count, ST_TRUNC};
    endfunction

    function automatic btw_result_t finish_header(input logic [31:0] len,
                                                  input logic [15:0] at);
        btw_result_t r;
        r = {w_tag, len, at + 16'd1, w_count, ST_OK};
        w_count = w_count + 8'd1;
        if (len == 0) begin
            w_phase = WALK_TAG;
        end else begin
            w_skip  = len;
            w_phase = WALK_SKIP;
        end
        return r;
    endfunction

    // advances the walker by one byte; returns 1 when a result beat is due
    function automatic bit walk_byte(input logic [7:0] b, input logic f, input logic l,
                                     output btw_result_t r);
        logic [15:0] at;
        bit hit;
        hit = 1'b0;
        r = '0;
        if (f) restart_walk();
        if (w_stopped) return 1'b0;
        at = w_pos;
        w_pos = w_pos + 16'd1;
        case (w_phase)
            WALK_TAG: begin
                if (w_count >= w_limit) begin
                    w_stopped = 1'b1;
                end else if (is_known_tag(b)) begin
                    w_tag = b;
                    w_phase = WALK_LEN;
                    if (l) begin
                        r = truncated_header();
                        hit = 1'b1;
                    end
                end else begin
                    r = {b, 32'd0, 16'd0, w_count, ST_UNKNOWN};
                    hit = 1'b1;
                    w_stopped = 1'b1;
                end
            end
            WALK_LEN: begin
                if (!b[7]) begin
                    r = finish_header({24'd0, b}, at);
                    hit = 1'b1;
                end else begin
                    w_len_left = b[6:0];
                    w_acc = '0;
                    if (w_len_left == 0) begin
                        r = finish_header(32'd0, at);
                        hit = 1'b1;
                    end else begin
                        w_phase = WALK_LONG;
                        if (l) begin
                            r = truncated_header();
                            hit = 1'b1;
                        end
                    end
                end
            end
            WALK_LONG: begin
                w_acc = {w_acc[23:0], b};
                w_len_left = w_len_left - 7'd1;
                if (w_len_left == 0) begin
                    r = finish_header(w_acc, at);
                    hit = 1'b1;
                end else if (l) begin
                    r = truncated_header();
                    hit = 1'b1;
                end
            end
            default: begin
                if (w_skip != 0) w_skip = w_skip - 32'd1;
                if (w_skip == 0) w_phase = WALK_TAG;
            end
        endcase
        if (l) w_stopped = 1'b1;
        return hit;
    endfunction

    // entered and left at a falling edge with s_valid not yet assigned there
    task automatic drive_byte(input logic [7:0] d, input logic f, input logic l);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_data_byte  <= d;
        s_first_byte <= f;
        s_last_byte  <= l;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic send_byte(input msg_byte_t item);
        btw_result_t r;
        if (walk_byte(item.data, item.first, item.last, r)) header_q.push_back(r);
        drive_byte(item.data, item.first, item.last);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (header_q.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_limit(input logic [7:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        w_limit = v;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic add_row(input logic [7:0] d, input logic f, input logic l,
                           input logic typed, input btw_result_t r);
        dir_rows.push_back({{d, f, l}, typed, r});
    endtask

    task automatic build_message();
        int n_el, len, nlen, nc, cut;
        logic [7:0] tag;
        msg_q.delete();
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 8))
                msg_q.push_back({8'($urandom), 1'($urandom_range(0, 3) == 0),
                                 1'($urandom_range(0, 3) == 0)});
            return;
        end
        n_el = $urandom_range(1, 10);
        for (int e = 0; e < n_el; e++) begin
            if ($urandom_range(0, 24) == 0) begin
                tag = 8'($urandom);
                if (is_known_tag(tag)) tag = 8'hff;
            end else begin
                case ($urandom_range(0, 3))
                    0: tag = TAG_BOOLEAN;
                    1: tag = TAG_NULL;
                    2: tag = TAG_OID;
                    default: tag = TAG_SEQUENCE;
                endcase
            end
            msg_q.push_back({tag, 1'b0, 1'b0});
            case ($urandom_range(0, 19))
                0, 1: begin
                    len = $urandom_range(7, 127);
                    msg_q.push_back({8'(len), 1'b0, 1'b0});
                end
                2, 3: begin
                    len = 0;
                    msg_q.push_back({LEN_LONG_FORM, 1'b0, 1'b0});
                end
                4, 5, 6: begin
                    nlen = $urandom_range(1, 4);
                    len = $urandom_range(0, 6);
                    msg_q.push_back({LEN_LONG_FORM | 8'(nlen), 1'b0, 1'b0});
                    repeat (nlen - 1) msg_q.push_back({8'h00, 1'b0, 1'b0});
                    msg_q.push_back({8'(len), 1'b0, 1'b0});
                end
                7: begin
                    nlen = $urandom_range(1, 6);
                    len = 1000;
                    msg_q.push_back({LEN_LONG_FORM | 8'(nlen), 1'b0, 1'b0});
                    repeat (nlen) msg_q.push_back({8'($urandom), 1'b0, 1'b0});
                end
                default: begin
                    len = $urandom_range(0, 6);
                    msg_q.push_back({8'(len), 1'b0, 1'b0});
                end
            endcase
            nc = (len > 24) ? $urandom_range(0, 24) : len;
            repeat (nc) msg_q.push_back({8'($urandom), 1'b0, 1'b0});
        end
        if ($urandom_range(0, 9) == 0) begin
            cut = $urandom_range(1, msg_q.size());
            while (msg_q.size() > cut) void'(msg_q.pop_back());
        end
        msg_q[0].first = ($urandom_range(0, 19) != 0);
        msg_q[msg_q.size() - 1].last = ($urandom_range(0, 9) != 0);
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 3)) msg_q.push_back({8'($urandom), 1'b0, 1'b0});
    endtask

    // result beat checker
    btw_result_t got_beat, want_beat;

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            got_beat = {m_element_tag, m_content_length, m_content_offset,
                        m_element_index, m_status};
            if (header_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected beat tag=%h len=%h off=%h idx=%h st=%0d",
                             $realtime, got_beat.element_tag, got_beat.content_length,
                             got_beat.content_offset, got_beat.element_index,
                             got_beat.status);
            end else begin
                want_beat = header_q.pop_front();
                if (got_beat.element_tag !== want_beat.element_tag
                        || got_beat.content_length !== want_beat.content_length
                        || got_beat.content_offset !== want_beat.content_offset
                        || got_beat.element_index !== want_beat.element_index
                        || got_beat.status !== want_beat.status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: mismatch exp tag=%h len=%h off=%h idx=%h st=%0d",
                                 $realtime, want_beat.element_tag,
                                 want_beat.content_length, want_beat.content_offset,
                                 want_beat.element_index, want_beat.status,
                                 " / got tag=%h len=%h off=%h idx=%h st=%0d",
                                 got_beat.element_tag, got_beat.content_length,
                                 got_beat.content_offset, got_beat.element_index,
                                 got_beat.status);
                end
            end
        end
    end

    // receiver
    initial begin
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
                m_ready <= 1'b1;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        #20_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        int limits [6];
        int targets [6];
        int sent;
        bit held, paused;
        btw_result_t r;
        bit hit;

        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        s_valid      = 1'b0;
        s_data_byte  = '0;
        s_first_byte = 1'b0;
        s_last_byte  = 1'b0;
        mismatches   = 0;
        idle_on      = 1'b1;
        hold_req     = 1'b0;
        held         = 1'b0;
        paused       = 1'b0;
        w_limit      = MAX_ELEMENTS_RESET;
        restart_walk();

        // no first byte after reset: walk starts at position zero
        add_row(TAG_SEQUENCE, 1'b0, 1'b0, 1'b0, '0);
        add_row(8'h01, 1'b0, 1'b0, 1'b1, {TAG_SEQUENCE, 32'd1, 16'd2, 8'd0, ST_OK});
        add_row(8'hff, 1'b0, 1'b0, 1'b0, '0);
        add_row(TAG_BOOLEAN, 1'b0, 1'b0, 1'b0, '0);
        add_row(LEN_LONG_FORM, 1'b0, 1'b0, 1'b1,
                {TAG_BOOLEAN, 32'd0, 16'd5, 8'd1, ST_OK});
        add_row(TAG_NULL, 1'b0, 1'b0, 1'b0, '0);
        add_row(8'h82, 1'b0, 1'b0, 1'b0, '0);
        add_row(8'h00, 1'b0, 1'b0, 1'b0, '0);
        add_row(8'h00, 1'b0, 1'b0, 1'b1, {TAG_NULL, 32'd0, 16'd9, 8'd2, ST_OK});
        add_row(TAG_OID, 1'b0, 1'b0, 1'b0, '0);
        add_row(8'h00, 1'b0, 1'b0, 1'b1, {TAG_OID, 32'd0, 16'd11, 8'd3, ST_OK});
        add_row(8'h02, 1'b0, 1'b0, 1'b1, {8'h02, 32'd0, 16'd0, 8'd4, ST_UNKNOWN});
        // five length bytes, only the low 32 bits kept
        add_row(TAG_OID, 1'b1, 1'b0, 1'b0, '0);
        add_row(8'h85, 1'b0, 1'b0, 1'b0, '0);
        repeat (4) add_row(8'hff, 1'b0, 1'b0, 1'b0, '0);
        add_row(8'hff, 1'b0, 1'b0, 1'b1, {TAG_OID, 32'hffff_ffff, 16'd7, 8'd0, ST_OK});
        add_row(TAG_SEQUENCE, 1'b1, 1'b1, 1'b1,
                {TAG_SEQUENCE, 32'd0, 16'd0, 8'd0, ST_TRUNC});
        add_row(TAG_BOOLEAN, 1'b1, 1'b0, 1'b0, '0);
        add_row(8'h82, 1'b0, 1'b0, 1'b0, '0);
        add_row(8'h12, 1'b0, 1'b1, 1'b1, {TAG_BOOLEAN, 32'd0, 16'd0, 8'd0, ST_TRUNC});
        add_row(TAG_SEQUENCE, 1'b1, 1'b0, 1'b0, '0);
        add_row(8'h7f, 1'b0, 1'b0, 1'b1, {TAG_SEQUENCE, 32'd127, 16'd2, 8'd0, ST_OK});
        add_row(8'h11, 1'b0, 1'b1, 1'b0, '0);

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (dir_rows[i]) begin
            hit = walk_byte(dir_rows[i].beat.data, dir_rows[i].beat.first,
                            dir_rows[i].beat.last, r);
            if (dir_rows[i].typed) header_q.push_back(dir_rows[i].result);
            else if (hit) header_q.push_back(r);
            drive_byte(dir_rows[i].beat.data, dir_rows[i].beat.first,
                       dir_rows[i].beat.last);
        end

        limits  = '{1, 255, 0, 3, $urandom_range(2, 254), 9};
        targets = '{130, 230, 40, 160, 160, 210};
        for (int p = 0; p < 6; p++) begin
            drain_results();
            write_limit(8'(limits[p]));
            if (p == 5) idle_on = 1'b0;
            sent = 0;
            while (sent < targets[p]) begin
                build_message();
                foreach (msg_q[i]) begin
                    send_byte(msg_q[i]);
                    sent++;
                    if (p == 1 && !held && sent >= 20) begin
                        hold_req = 1'b1;
                        held = 1'b1;
                    end
                end
                if (p == 3 && !paused && sent >= targets[p] / 2) begin
                    drain_results();
                    paused = 1'b1;
                end
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (mismatches == 0 && header_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

FILE: ber_tlv_header_walker.f
rtl/btw_pkg.sv
rtl/btw_walker.sv
rtl/btw_out_reg.sv
rtl/ber_tlv_header_walker.sv
sim/ber_tlv_header_walker_tb.sv
